FILE: rtl/bracket_frame_command_decoder_assert.svh
// Assertion macros for the bracket frame command decoder.
// Used by the top level; no other dependencies.
`ifndef BRACKET_FRAME_COMMAND_DECODER_ASSERT_SVH
`define BRACKET_FRAME_COMMAND_DECODER_ASSERT_SVH

// cond holds at every clock edge out of reset
`define BFCD_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

// ante at one edge implies cons at the next
`define BFCD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bfcd_pkg.sv
// Shared types, constants and code tables for the bracket frame command decoder.
// No dependencies.
package bfcd_pkg;

    localparam int FRAME_CAPACITY = 64;
    localparam int HEAD_DEPTH     = 8;
    localparam int HEAD_IDX_W     = $clog2(HEAD_DEPTH);
    localparam int CNT_W          = $clog2(FRAME_CAPACITY);
    localparam int NUM_CMDS       = 9;

    localparam int CMD_W  = 4;
    localparam int PORT_W = 2;
    localparam int SW_W   = 2;
    localparam int PLEN_W = 6;

    localparam logic [7:0] CHR_OPEN  = 8'h5B; // '['
    localparam logic [7:0] CHR_CLOSE = 8'h5D; // ']'
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_P     = 8'h50;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_ONE   = 8'h31;
    localparam logic [7:0] CHR_THREE = 8'h33;

    localparam logic [CMD_W-1:0]  CMD_INVALID = CMD_W'(9);
    localparam logic [PORT_W-1:0] PORT_NONE   = '0;
    localparam logic [SW_W-1:0]   SW_OFF      = SW_W'(0);
    localparam logic [SW_W-1:0]   SW_ON       = SW_W'(1);
    localparam logic [SW_W-1:0]   SW_ABSENT   = SW_W'(2);
    localparam logic [PLEN_W-1:0] PLEN_MAX    = '1;

    // two-letter command codes, index = command value
    localparam logic [NUM_CMDS-1:0][15:0] CMD_CODES = '{
        16'h4943, // 8 IC
        16'h434C, // 7 CL
        16'h4752, // 6 GR
        16'h4343, // 5 CC
        16'h5443, // 4 TC
        16'h5450, // 3 TP
        16'h4756, // 2 GV
        16'h4741, // 1 GA
        16'h4743  // 0 GC
    };

    typedef struct packed {
        logic                               in_frame;
        logic [CNT_W-1:0]                   count;
        logic [HEAD_DEPTH-1:0][7:0]         head;
    } frame_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [PORT_W-1:0] port;
        logic [SW_W-1:0]   switch_state;
        logic [PLEN_W-1:0] payload_length;
    } result_t;

endpackage

FILE: rtl/bfcd_frame_track.sv
// Frame state: in-frame flag, byte counter and the first eight frame bytes.
// Depends on bfcd_pkg.
module bfcd_frame_track import bfcd_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,
    input  logic [7:0]   rx_byte,
    output frame_state_t state
);

    logic                       in_frame_reg, in_frame_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [HEAD_DEPTH-1:0][7:0] head_reg;
    logic                       store;

    assign store = step && in_frame_reg && rx_byte != CHR_OPEN && rx_byte != CHR_CLOSE;

    always_comb begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        if (step) begin
            if (rx_byte == CHR_OPEN) begin
                in_frame_next = 1'b1;
                count_next    = '0;
            end else if (in_frame_reg && rx_byte == CHR_CLOSE) begin
                in_frame_next = 1'b0;
                count_next    = '0;
            end else if (in_frame_reg) begin
                count_next = count_reg + 1'b1;
            end
            // overflow: drop the frame silently
            if (count_next >= CNT_W'(FRAME_CAPACITY - 1)) begin
                in_frame_next = 1'b0;
                count_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
        end
    end

    // head bytes carry no reset
    always_ff @(posedge aclk) begin
        if (store && count_reg < CNT_W'(HEAD_DEPTH)) begin
            head_reg[count_reg[HEAD_IDX_W-1:0]] <= rx_byte;
        end
    end

    assign state.in_frame = in_frame_reg;
    assign state.count    = count_reg;
    assign state.head     = head_reg;

endmodule

FILE: rtl/bfcd_decode.sv
// Field decode of a closed frame from the kept head bytes and the count.
// Depends on bfcd_pkg.
module bfcd_decode import bfcd_pkg::*; (
    input  frame_state_t state,
    output result_t      result
);

    localparam int CMP_W = (CNT_W > PLEN_W) ? CNT_W : PLEN_W;

    logic [CNT_W-1:0] diff;
    logic             found;

    always_comb begin
        result.command = CMD_INVALID;
        found          = 1'b0;
        if (state.count >= CNT_W'(3) && state.head[2] == CHR_SPACE) begin
            for (int k = 0; k < NUM_CMDS; k++) begin
                if (!found && {state.head[0], state.head[1]} == CMD_CODES[k]) begin
                    result.command = CMD_W'(k);
                    found          = 1'b1;
                end
            end
        end
    end

    always_comb begin
        result.port = PORT_NONE;
        if (state.count >= CNT_W'(6) && state.head[3] == CHR_P &&
            state.head[5] == CHR_SPACE &&
            state.head[4] >= CHR_ONE && state.head[4] <= CHR_THREE) begin
            // '1'..'3' low bits give 1..3
            result.port = state.head[4][PORT_W-1:0];
        end
    end

    always_comb begin
        result.switch_state = SW_ABSENT;
        if (state.count >= CNT_W'(8) && state.head[7] == CHR_SPACE) begin
            if (state.head[6] == CHR_ONE) begin
                result.switch_state = SW_ON;
            end else if (state.head[6] == CHR_ZERO) begin
                result.switch_state = SW_OFF;
            end
        end
    end

    always_comb begin
        diff                  = state.count - CNT_W'(3);
        result.payload_length = '0;
        if (state.count > CNT_W'(3)) begin
            if (CMP_W'(diff) > CMP_W'(PLEN_MAX)) begin
                result.payload_length = PLEN_MAX;
            end else begin
                result.payload_length = PLEN_W'(diff);
            end
        end
    end

endmodule

FILE: rtl/bracket_frame_command_decoder.sv
// Top level of the bracket frame command decoder: input register, frame
// tracking, field decode and result register. Depends on bfcd_pkg,
// bfcd_frame_track, bfcd_decode and bracket_frame_command_decoder_assert.svh.
//
// Usage:
//   s_ channel: one received serial character per item (s_rx_byte).
//   m_ channel: one result item per frame closed by ']', carrying the
//   command code, port, switch state and payload length.
//   '[' opens a frame (also inside one); bytes between are counted and the
//   first eight kept. A frame that reaches FRAME_CAPACITY - 1 bytes is
//   dropped without a result. Bytes outside a frame produce nothing.
// Timing:
//   An item taken sits in the input register and is decoded there; for a
//   closing ']' the result is loaded into the result register as the item
//   leaves, which a result still waiting on m_ready can hold back. One
//   item per cycle is sustained while no ']' is held back; the frame counter
//   update and the decode of the head bytes both fit in the cycle it leaves.
// Reset: aresetn (synchronous, low) leaves the block out of a frame with
//   an empty count and both registers empty.
// Stall: while a result waits on m_ready, bytes that produce no result
//   still flow; a closing ']' waits in the input register until the
//   result register frees, and s_ready drops only then.
module bracket_frame_command_decoder import bfcd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_rx_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CMD_W-1:0]  m_command,
    output logic [PORT_W-1:0] m_port,
    output logic [SW_W-1:0]   m_switch_state,
    output logic [PLEN_W-1:0] m_payload_length
);

`include "bracket_frame_command_decoder_assert.svh"

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // result register
    logic       m_valid_reg, m_valid_next;
    result_t    m_result_reg;

    frame_state_t fstate;
    result_t      dec_result;
    logic         close_hit;
    logic         advance;
    logic         out_load;

    // a ']' inside a frame is the only byte that yields a result
    assign close_hit = in_valid_reg && fstate.in_frame && in_byte_reg == CHR_CLOSE;
    assign advance   = in_valid_reg && (!close_hit || !m_valid_reg || m_ready);
    assign out_load  = advance && close_hit;
    assign s_ready   = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (out_load) begin
            m_result_reg <= dec_result;
        end
    end

    bfcd_frame_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .state   (fstate)
    );

    // decode reads the state before the closing byte is applied
    bfcd_decode u_decode (
        .state  (fstate),
        .result (dec_result)
    );

    assign m_valid          = m_valid_reg;
    assign m_command        = m_result_reg.command;
    assign m_port           = m_result_reg.port;
    assign m_switch_state   = m_result_reg.switch_state;
    assign m_payload_length = m_result_reg.payload_length;

    `BFCD_ASSERT_ALWAYS(a_idle_count_zero, aclk, aresetn,
        fstate.in_frame || fstate.count == '0, "count nonzero outside a frame")
    `BFCD_ASSERT_ALWAYS(a_count_below_cap, aclk, aresetn,
        fstate.count < CNT_W'(FRAME_CAPACITY - 1), "count reached capacity")
    `BFCD_ASSERT_NEXT(a_open_starts_frame, aclk, aresetn,
        advance && in_byte_reg == CHR_OPEN,
        fstate.in_frame && fstate.count == '0, "open byte did not start a frame")
    `BFCD_ASSERT_NEXT(a_close_gives_result, aclk, aresetn,
        out_load, m_valid && !fstate.in_frame, "close byte gave no result")

endmodule
